// ===== rtl/gmuf_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid maze generator package
// Shared widths, codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gmuf_pkg;

   localparam int CMD_W     = 2;
   localparam int COORD_W   = 5;
   localparam int CFG_W     = 6;
   localparam int CSR_IDX_W = 2;

   localparam int DEF_MAX_WIDTH  = 32;
   localparam int DEF_MAX_HEIGHT = 32;
   localparam int CFG_RESET      = 32;

   localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ATTEMPT = 2'd1;

   localparam logic SIDE_RIGHT = 1'b0;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INDEX,
      ST_WALL,
      ST_FIND_A,
      ST_FIND_B,
      ST_COUNT,
      ST_MERGE,
      ST_DONE
   } gmuf_state_type;

   typedef struct packed {
      logic take;
      logic clr_write;
      logic clr_finish;
      logic calc;
      logic walk_cur;
      logic walk_next;
      logic root_a;
      logic cnt_rb;
      logic cnt_ra;
      logic merge;
      logic load_rsp;
   } gmuf_cmd_type;

   typedef struct packed {
      logic req_is_start;
      logic clr_last;
      logic attempt_ok;
      logic at_root;
      logic same_root;
   } gmuf_stat_type;

endpackage

// ===== rtl/gmuf_if.sv =====
// ----------------------------------------------------------------------------
// Grid maze generator channels
// Valid and ready channels for request beats, response beats and
// register writes.
// ----------------------------------------------------------------------------
interface gmuf_req_if import gmuf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [COORD_W-1:0] cell_x;
   logic [COORD_W-1:0] cell_y;
   logic               wall_side;

   modport source (output valid, cmd, cell_x, cell_y, wall_side, input ready);
   modport sink (input valid, cmd, cell_x, cell_y, wall_side, output ready);
endinterface

interface gmuf_rsp_if;
   logic valid;
   logic ready;
   logic wall_removed;
   logic maze_complete;
   logic right_present;
   logic bottom_present;

   modport source (output valid, wall_removed, maze_complete, right_present,
                   bottom_present, input ready);
   modport sink (input valid, wall_removed, maze_complete, right_present,
                 bottom_present, output ready);
endinterface

interface gmuf_csr_if import gmuf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// ===== rtl/grid_maze_union_find_generator.sv =====
// ----------------------------------------------------------------------------
// Grid maze generator top level
// Randomized Kruskal maze builder over a union-find forest with union by size.
// A query or a rejected attempt goes from the wall check straight to the
// response beat. An attempt walks the parent links of both cells to their
// roots, then joins the two sets, or skips the union when both cells share
// a root. Start: a clearing pass over width * height memory cells; reset
// runs the same pass and no request beat is taken until it ends.
// ----------------------------------------------------------------------------
module grid_maze_union_find_generator import gmuf_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input logic        clock,
   input logic        reset,
   gmuf_req_if.sink   req_bus,
   gmuf_rsp_if.source rsp_bus,
   gmuf_csr_if.sink   csr_bus
);

   gmuf_cmd_type  ctl;
   gmuf_stat_type stat;

   assign csr_bus.ready = 1'b1;

   gmuf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   gmuf_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .stat               (stat),
      .req_cmd            (req_bus.cmd),
      .req_cell_x         (req_bus.cell_x),
      .req_cell_y         (req_bus.cell_y),
      .req_wall_side      (req_bus.wall_side),
      .csr_we             (csr_bus.valid),
      .csr_index          (csr_bus.index),
      .csr_wdata          (csr_bus.wdata),
      .rsp_wall_removed   (rsp_bus.wall_removed),
      .rsp_maze_complete  (rsp_bus.maze_complete),
      .rsp_right_present  (rsp_bus.right_present),
      .rsp_bottom_present (rsp_bus.bottom_present)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request taken while an earlier one is in flight");

   a_removed_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.wall_removed
         |-> !(rsp_bus.right_present && rsp_bus.bottom_present))
      else $error("removed wall still reported present");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(ctl))
      else $error("overlapping datapath commands");

   a_merge_roots: assert property (@(posedge clock) disable iff (reset)
      ctl.merge |-> !stat.same_root)
      else $error("union of a set with itself");

endmodule

// ===== rtl/gmuf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Grid maze generator controller
// Sequences the clearing pass, the two root walks, the union and the
// response beat, and owns the request and response handshakes.
// ----------------------------------------------------------------------------
module gmuf_ctrl import gmuf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  gmuf_stat_type stat,
   output gmuf_cmd_type  ctl
);

   gmuf_state_type state_ff, state_in;
   logic           boot_ff, boot_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) begin
               state_in = boot_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.req_is_start ? ST_CLEAR : ST_INDEX;
            end
         end
         ST_INDEX: state_in = ST_WALL;
         ST_WALL: state_in = stat.attempt_ok ? ST_FIND_A : ST_DONE;
         ST_FIND_A: begin
            if (stat.at_root) begin
               state_in = ST_FIND_B;
            end
         end
         ST_FIND_B: begin
            if (stat.at_root) begin
               state_in = stat.same_root ? ST_DONE : ST_COUNT;
            end
         end
         ST_COUNT: state_in = ST_MERGE;
         ST_MERGE: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clr_write  = !stat.clr_last;
            ctl.clr_finish = stat.clr_last;
         end
         ST_IDLE: ctl.take = req_valid;
         ST_INDEX: ctl.calc = 1'b1;
         ST_WALL: ctl.walk_cur = stat.attempt_ok;
         ST_FIND_A: begin
            ctl.root_a    = stat.at_root;
            ctl.walk_next = !stat.at_root;
         end
         ST_FIND_B: begin
            ctl.cnt_rb    = stat.at_root && !stat.same_root;
            ctl.walk_next = !stat.at_root;
         end
         ST_COUNT: ctl.cnt_ra = 1'b1;
         ST_MERGE: ctl.merge = 1'b1;
         ST_DONE: ctl.load_rsp = !rsp_valid_ff || rsp_ready;
         default: ctl = '0;
      endcase
   end

   always_comb begin
      boot_in = boot_ff && !(state_ff == ST_CLEAR && stat.clr_last);
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         boot_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/gmuf_dp.sv =====
// ----------------------------------------------------------------------------
// Grid maze generator datapath
// Holds the wall, parent and set size memories, the grid registers, the
// root walker and the response register.
// ----------------------------------------------------------------------------
module gmuf_dp import gmuf_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gmuf_cmd_type         ctl,
   output gmuf_stat_type        stat,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [COORD_W-1:0]   req_cell_x,
   input  logic [COORD_W-1:0]   req_cell_y,
   input  logic                 req_wall_side,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output logic                 rsp_wall_removed,
   output logic                 rsp_maze_complete,
   output logic                 rsp_right_present,
   output logic                 rsp_bottom_present
);

   localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
   localparam int IDX_W  = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int DW_A   = $clog2(MAX_WIDTH + 1);
   localparam int DH_A   = $clog2(MAX_HEIGHT + 1);
   localparam int DWH    = (DW_A > DH_A) ? DW_A : DH_A;
   localparam int DIM_W  = (DWH > CFG_W) ? DWH : CFG_W;
   localparam int TOT_W  = 2 * DIM_W;
   localparam int YM_W   = COORD_W + DIM_W;
   localparam int PROD_W = YM_W + IDX_W;
   localparam int RST_W  = (CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET;
   localparam int RST_H  = (CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET;

   logic [CFG_W-1:0]   grid_width_ff, grid_width_in;
   logic [CFG_W-1:0]   grid_height_ff, grid_height_in;
   logic [DIM_W-1:0]   act_w_ff, act_w_in;
   logic [DIM_W-1:0]   act_h_ff, act_h_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [COORD_W-1:0] x_ff, x_in;
   logic [COORD_W-1:0] y_ff, y_in;
   logic               side_ff, side_in;
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic [IDX_W-1:0]   nxt_ff, nxt_in;
   logic               inside_ff, inside_in;
   logic               ok_ff, ok_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic               complete_ff, complete_in;
   logic               removed_ff, removed_in;
   logic [IDX_W-1:0]   walk_ff, walk_in;
   logic [IDX_W-1:0]   ra_ff, ra_in;
   logic [IDX_W-1:0]   rb_ff, rb_in;
   logic [CNT_W-1:0]   cb_ff, cb_in;
   logic               rsp_removed_ff, rsp_complete_ff, rsp_right_ff, rsp_bottom_ff;

   logic [IDX_W-1:0] parent_mem [CELLS];
   logic [CNT_W-1:0] count_mem [CELLS];
   logic             right_mem [CELLS];
   logic             bottom_mem [CELLS];
   logic [IDX_W-1:0] pq;
   logic [CNT_W-1:0] cq;
   logic             rq, bq;

   logic [DIM_W-1:0]  cfg_w, cfg_h, clamp_w, clamp_h;
   logic [TOT_W-1:0]  total;
   logic [YM_W-1:0]   ymul;
   logic [PROD_W-1:0] cur_full, nxt_full;
   logic              clr_we, a_small;
   logic [IDX_W-1:0]  child, root, p_wa, p_wd, c_ra, c_wa;
   logic [CNT_W-1:0]  sum, c_wd;
   logic              right_hit, bottom_hit;

   always_comb begin
      cfg_w = DIM_W'(grid_width_ff);
      cfg_h = DIM_W'(grid_height_ff);
      if (cfg_w == '0) begin
         clamp_w = DIM_W'(1);
      end else if (cfg_w > DIM_W'(MAX_WIDTH)) begin
         clamp_w = DIM_W'(MAX_WIDTH);
      end else begin
         clamp_w = cfg_w;
      end
      if (cfg_h == '0) begin
         clamp_h = DIM_W'(1);
      end else if (cfg_h > DIM_W'(MAX_HEIGHT)) begin
         clamp_h = DIM_W'(MAX_HEIGHT);
      end else begin
         clamp_h = cfg_h;
      end
      total    = TOT_W'(act_w_ff) * TOT_W'(act_h_ff);
      ymul     = YM_W'(y_ff) * YM_W'(act_w_ff);
      cur_full = PROD_W'(ymul) + PROD_W'(x_ff);
      nxt_full = cur_full + ((side_ff == SIDE_RIGHT) ? PROD_W'(1) : PROD_W'(act_w_ff));
      a_small  = cq < cb_ff;
      child    = a_small ? ra_ff : rb_ff;
      root     = a_small ? rb_ff : ra_ff;
      sum      = cq + cb_ff;
      clr_we   = ctl.clr_write || ctl.clr_finish;
   end

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_GRID_WIDTH:  grid_width_in  = csr_wdata;
            REG_GRID_HEIGHT: grid_height_in = csr_wdata;
            default: ;
         endcase
      end
      act_w_in    = act_w_ff;
      act_h_in    = act_h_ff;
      cmd_in      = cmd_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      side_in     = side_ff;
      removed_in  = removed_ff;
      if (ctl.take) begin
         cmd_in     = req_cmd;
         x_in       = req_cell_x;
         y_in       = req_cell_y;
         side_in    = req_wall_side;
         removed_in = 1'b0;
         if (req_cmd == CMD_START) begin
            act_w_in = clamp_w;
            act_h_in = clamp_h;
         end
      end
      cur_in    = cur_ff;
      nxt_in    = nxt_ff;
      inside_in = inside_ff;
      ok_in     = ok_ff;
      if (ctl.calc) begin
         inside_in = (DIM_W'(x_ff) < act_w_ff) && (DIM_W'(y_ff) < act_h_ff);
         cur_in    = inside_in ? cur_full[IDX_W-1:0] : '0;
         nxt_in    = nxt_full[IDX_W-1:0];
         ok_in     = (side_ff == SIDE_RIGHT) ? (DIM_W'(x_ff) + DIM_W'(1) < act_w_ff)
                                             : (DIM_W'(y_ff) + DIM_W'(1) < act_h_ff);
      end
      clr_in      = clr_ff;
      complete_in = complete_ff;
      if (ctl.clr_write) begin
         clr_in = clr_ff + IDX_W'(1);
      end
      if (ctl.clr_finish) begin
         clr_in      = '0;
         complete_in = (total == TOT_W'(1));
      end
      if (ctl.merge) begin
         removed_in  = 1'b1;
         complete_in = complete_ff || (TOT_W'(sum) >= total);
      end
      if (ctl.walk_cur) begin
         walk_in = cur_ff;
      end else if (ctl.walk_next) begin
         walk_in = pq;
      end else if (ctl.root_a) begin
         walk_in = nxt_ff;
      end else begin
         walk_in = walk_ff;
      end
      ra_in = ctl.root_a ? walk_ff : ra_ff;
      rb_in = ctl.cnt_rb ? walk_ff : rb_ff;
      cb_in = ctl.cnt_ra ? cq : cb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= CFG_W'(CFG_RESET);
         grid_height_ff <= CFG_W'(CFG_RESET);
         act_w_ff       <= DIM_W'(RST_W);
         act_h_ff       <= DIM_W'(RST_H);
         clr_ff         <= '0;
         complete_ff    <= 1'b0;
         removed_ff     <= 1'b0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         act_w_ff       <= act_w_in;
         act_h_ff       <= act_h_in;
         clr_ff         <= clr_in;
         complete_ff    <= complete_in;
         removed_ff     <= removed_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      side_ff   <= side_in;
      cur_ff    <= cur_in;
      nxt_ff    <= nxt_in;
      inside_ff <= inside_in;
      ok_ff     <= ok_in;
      walk_ff   <= walk_in;
      ra_ff     <= ra_in;
      rb_ff     <= rb_in;
      cb_ff     <= cb_in;
   end

   always_comb begin
      p_wa = clr_we ? clr_ff : child;
      p_wd = clr_we ? clr_ff : root;
      c_wa = clr_we ? clr_ff : root;
      c_wd = clr_we ? CNT_W'(1) : sum;
      c_ra = ctl.cnt_rb ? walk_ff : ra_ff;
   end

   always_ff @(posedge clock) begin
      if (clr_we || ctl.merge) begin
         parent_mem[p_wa] <= p_wd;
      end
      pq <= parent_mem[walk_in];
   end

   always_ff @(posedge clock) begin
      if (clr_we || ctl.merge) begin
         count_mem[c_wa] <= c_wd;
      end
      cq <= count_mem[c_ra];
   end

   always_ff @(posedge clock) begin
      if (clr_we) begin
         right_mem[clr_ff] <= 1'b1;
      end else if (ctl.merge && side_ff == SIDE_RIGHT) begin
         right_mem[cur_ff] <= 1'b0;
      end
      rq <= right_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (clr_we) begin
         bottom_mem[clr_ff] <= 1'b1;
      end else if (ctl.merge && side_ff != SIDE_RIGHT) begin
         bottom_mem[cur_ff] <= 1'b0;
      end
      bq <= bottom_mem[cur_ff];
   end

   always_comb begin
      right_hit  = removed_ff && (side_ff == SIDE_RIGHT);
      bottom_hit = removed_ff && (side_ff != SIDE_RIGHT);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_rsp) begin
         rsp_removed_ff  <= removed_ff;
         rsp_complete_ff <= complete_ff;
         if (cmd_ff == CMD_START || !inside_ff) begin
            rsp_right_ff  <= 1'b1;
            rsp_bottom_ff <= 1'b1;
         end else begin
            rsp_right_ff  <= rq && !right_hit;
            rsp_bottom_ff <= bq && !bottom_hit;
         end
      end
   end

   always_comb begin
      stat.req_is_start = (req_cmd == CMD_START);
      stat.clr_last     = (TOT_W'(clr_ff) + TOT_W'(1) == total);
      stat.attempt_ok   = (cmd_ff == CMD_ATTEMPT) && inside_ff && ok_ff && !complete_ff;
      stat.at_root      = (pq == walk_ff);
      stat.same_root    = (walk_ff == ra_ff);
   end

   assign rsp_wall_removed   = rsp_removed_ff;
   assign rsp_maze_complete  = rsp_complete_ff;
   assign rsp_right_present  = rsp_right_ff;
   assign rsp_bottom_present = rsp_bottom_ff;

endmodule
